### rtl/efsa_pkg.sv
// ----------------------------------------------------------------------------
// efsa_pkg
// shared types and constants of the eased fade/scale animator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efsa_pkg;

  // action codes on the input stream
  localparam logic [1:0] ACT_OPEN  = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_kind_e;

  // one classified word handed from front to back
  typedef struct packed {
    cmd_kind_e    kind;
    logic [15:0]  handle;
    logic [31:0]  time_ms;
  } cmd_t;

  // one finished result word
  typedef struct packed {
    logic [15:0] out_handle;
    logic [14:0] alpha;
    logic [14:0] scale;
    logic        done_res;
    logic        last;
  } result_t;

  localparam logic [15:0] ONE_Q14         = 16'd16384;
  localparam logic [14:0] OPEN_SCALE_FROM = 15'd13926;
  localparam logic [11:0] OPEN_SCALE_SPAN = 12'd2458;
  localparam logic [11:0] CLOSE_SCALE_SPAN = 12'd1966;
  localparam logic [14:0] CLOSE_SCALE_END = 15'd14418;

endpackage

### rtl/eased_fade_scale_animator.sv
// ----------------------------------------------------------------------------
// eased_fade_scale_animator
// window open/close animation table with spring and ease-out curves
// ----------------------------------------------------------------------------
// open and close words each add a table entry from the back end's idle
// state; a close on a full table goes through its own state and returns
// one finished word. a tick walks the table one entry at a time; each
// entry passes through the read, load, multiply, ease, scale and output
// states, and while the animation is still running progress also goes
// through the radix-16 divider, which works out the quotient and hands
// it back. a tick takes longer the more entries it has, set by that
// per-entry sequence and the single table write port, plus any time a
// result waits downstream. a two-word queue sits between the input side
// and the sequencer, and the result register lets the next word be taken
// while a result still waits downstream. the spring curve rom is built
// at elaboration, and the table needs no clearing pass after reset.
`timescale 1ns / 1ps

module eased_fade_scale_animator import efsa_pkg::*; #(
  parameter int MAX_ENTRIES     = 64,
  parameter int CURVE_ROM_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // handle[15:0], time_ms[47:16]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_handle[15:0], alpha[30:16],
                                      // scale[45:31], zero[47:46]
  output logic [0:0]  m_axis_tuser,   // done_res[0]
  output logic        m_axis_tlast,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic REG_OPEN_DUR  = 1'b0;
  localparam logic REG_CLOSE_DUR = 1'b1;

  logic [15:0] open_dur_q, close_dur_q;
  logic [15:0] open_eff, close_eff;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  result_t     res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_dur_q  <= 16'd300;
      close_dur_q <= 16'd200;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OPEN_DUR:  open_dur_q  <= cfg_data_i;
        REG_CLOSE_DUR: close_dur_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a zero duration behaves as one millisecond
  assign open_eff  = (open_dur_q == 16'd0) ? 16'd1 : open_dur_q;
  assign close_eff = (close_dur_q == 16'd0) ? 16'd1 : close_dur_q;

  efsa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_action_i(s_axis_tuser),
    .in_handle_i(s_axis_tdata[15:0]),
    .in_time_i  (s_axis_tdata[47:16]),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  efsa_back #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .CURVE_ROM_DEPTH(CURVE_ROM_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .open_dur_i (open_eff),
    .close_dur_i(close_eff),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {2'b00, res.scale, res.alpha, res.out_handle};
  assign m_axis_tuser = res.done_res;
  assign m_axis_tlast = res.last;

endmodule

### rtl/efsa_front.sv
// ----------------------------------------------------------------------------
// efsa_front
// accepts input words, drops unknown actions and queues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efsa_front import efsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_action_i,
  input  logic [15:0] in_handle_i,
  input  logic [31:0] in_time_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;
  cmd_t       cmd_new;

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cmd_new.handle  = in_handle_i;
    cmd_new.time_ms = in_time_i;
    push            = in_valid_i && in_ready_o;
    unique case (in_action_i)
      ACT_OPEN:  cmd_new.kind = CMD_OPEN;
      ACT_CLOSE: cmd_new.kind = CMD_CLOSE;
      ACT_TICK:  cmd_new.kind = CMD_TICK;
      default: begin
        // unknown action: taken and dropped
        cmd_new.kind = CMD_TICK;
        push         = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### rtl/efsa_div.sv
// ----------------------------------------------------------------------------
// efsa_div
// radix-16 restoring divider for progress, four quotient bits a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efsa_div import efsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,   // elapsed, already below divisor
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic [16:0] rem_q, rem_d;
  logic [15:0] quot_q, quot_d;
  logic [15:0] dvs_q;
  logic [1:0]  step_q;
  logic        busy_q;
  logic        done_q;

  // four dependent subtract steps per cycle
  always_comb begin
    logic [16:0] r;
    logic [16:0] sh;
    r      = rem_q;
    quot_d = quot_q;
    for (int b = 0; b < 4; b++) begin
      sh = {r[15:0], 1'b0};
      if (sh >= {1'b0, dvs_q}) begin
        r      = sh - {1'b0, dvs_q};
        quot_d = {quot_d[14:0], 1'b1};
      end else begin
        r      = sh;
        quot_d = {quot_d[14:0], 1'b0};
      end
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/efsa_back.sv
// ----------------------------------------------------------------------------
// efsa_back
// animation table, per-entry sequencer, easing and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efsa_back import efsa_pkg::*; #(
  parameter int MAX_ENTRIES     = 64,
  parameter int CURVE_ROM_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic [15:0] open_dur_i,
  input  logic [15:0] close_dur_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ROM_W  = $clog2(CURVE_ROM_DEPTH);
  localparam int PROD_W = 17 + ROM_W;
  localparam longint Q30    = longint'(1) << 30;
  localparam longint RomDen = longint'(CURVE_ROM_DEPTH - 1) * 64;

  typedef struct packed {
    logic [15:0] handle;
    logic        is_close;
    logic        started;
    logic [31:0] start_time;
  } entry_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_LOAD = 10'b0000000100,
    S_DIV  = 10'b0000001000,
    S_MUL1 = 10'b0000010000,
    S_MUL2 = 10'b0000100000,
    S_EASE = 10'b0001000000,
    S_SCL  = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_FULL = 10'b1000000000
  } state_e;

  // 1 - exp(-6x)cos(12x) in q2.14 via a taylor series and six squarings
  function automatic logic [15:0] curve_value(input int k);
    longint cr, ci, tr, ti, sr, si, nr, ni, d;
    cr = -((6 * Q30 * longint'(k) + RomDen / 2) / RomDen);
    ci = (12 * Q30 * longint'(k) + RomDen / 2) / RomDen;
    tr = Q30;
    ti = 0;
    sr = Q30;
    si = 0;
    for (int n = 1; n <= 7; n++) begin
      nr = (tr * cr - ti * ci) / Q30;
      ni = (tr * ci + ti * cr) / Q30;
      // taylor term divided by its step number
      case (n)
        1: begin tr = nr;     ti = ni;     end
        2: begin tr = nr / 2; ti = ni / 2; end
        3: begin tr = nr / 3; ti = ni / 3; end
        4: begin tr = nr / 4; ti = ni / 4; end
        5: begin tr = nr / 5; ti = ni / 5; end
        6: begin tr = nr / 6; ti = ni / 6; end
        default: begin tr = nr / 7; ti = ni / 7; end
      endcase
      sr = sr + tr;
      si = si + ti;
    end
    for (int n = 0; n < 6; n++) begin
      nr = (sr * sr - si * si) / Q30;
      ni = (2 * sr * si) / Q30;
      sr = nr;
      si = ni;
    end
    d = Q30 - sr;
    if (d < 0) d = 0;
    return 16'((d * 16384 + Q30 / 2) / Q30);
  endfunction

  logic [15:0] rom_tbl [CURVE_ROM_DEPTH];
  for (genvar g = 0; g < CURVE_ROM_DEPTH; g++) begin : g_rom
    assign rom_tbl[g] = curve_value(g);
  end

  entry_t mem [MAX_ENTRIES];

  state_e      state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] i_q;
  cmd_t        cmd_q;
  entry_t      rd_a_q, rd_b_q;
  logic [15:0] handle_q;
  logic        close_q;
  logic [16:0] p_q;
  logic [16:0] u_q;
  logic [33:0] uu_q;
  logic [50:0] cube_q;
  logic [ROM_W-1:0] idx_q;
  logic [15:0] rom_q;
  logic [15:0] e_q;
  logic [28:0] mul_q;
  logic        res_valid_q;
  result_t     res_q;

  logic [IDX_W-1:0] i_idx, last_idx, add_idx;
  logic        out_free;
  logic        res_load;
  logic        div_start, div_done;
  logic [15:0] div_quot;
  logic [31:0] start_sel, elapsed;
  logic [15:0] dur_sel;
  logic [16:0] u_new;
  logic [PROD_W-1:0] idx_full;
  logic [ROM_W:0]    idx_wide;
  logic [14:0] shifted;
  logic        ent_done;
  logic [CNT_W-1:0] next_i, next_count;

  assign i_idx    = i_q[IDX_W-1:0];
  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign add_idx  = count_q[IDX_W-1:0];
  assign out_free = !res_valid_q || res_ready_i;
  assign res_load = out_free && ((state_q == S_OUT) || (state_q == S_FULL));
  assign cmd_ready_o = (state_q == S_IDLE);

  // per-entry working values
  always_comb begin
    start_sel = rd_a_q.started ? rd_a_q.start_time : cmd_q.time_ms;
    elapsed   = cmd_q.time_ms - start_sel;
    dur_sel   = rd_a_q.is_close ? close_dur_i : open_dur_i;
    div_start = (state_q == S_LOAD) && (elapsed < {16'd0, dur_sel});
    u_new     = 17'h10000 - p_q;
    idx_full  = PROD_W'(p_q[15:0]) * PROD_W'(CURVE_ROM_DEPTH - 1) + PROD_W'(32768);
    idx_wide  = idx_full[PROD_W-1:16];
    shifted   = mul_q[28:14];
    ent_done  = p_q[16];
    next_count = ent_done ? count_q - CNT_W'(1) : count_q;
    next_i     = ent_done ? i_q : i_q + CNT_W'(1);
  end

  efsa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(elapsed[15:0]),
    .divisor_i (dur_sel),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      i_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.kind)
              CMD_OPEN, CMD_CLOSE: begin
                if (count_q < CNT_W'(MAX_ENTRIES)) begin
                  count_q <= count_q + CNT_W'(1);
                end else if (cmd_i.kind == CMD_CLOSE) begin
                  state_q <= S_FULL;
                end
              end
              CMD_TICK: begin
                i_q <= '0;
                if (count_q != '0) state_q <= S_RD;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_RD:   state_q <= S_LOAD;
        S_LOAD: state_q <= div_start ? S_DIV : S_MUL1;
        S_DIV:  if (div_done) state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_EASE;
        S_EASE: state_q <= S_SCL;
        S_SCL:  state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            count_q     <= next_count;
            i_q         <= next_i;
            state_q     <= (next_i >= next_count) ? S_IDLE : S_RD;
          end
        end
        S_FULL: begin
          if (out_free) begin
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // table port and datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cmd_q <= cmd_i;
        if (cmd_valid_i && cmd_i.kind != CMD_TICK &&
            count_q < CNT_W'(MAX_ENTRIES)) begin
          mem[add_idx] <= '{handle: cmd_i.handle, is_close: (cmd_i.kind == CMD_CLOSE),
                            started: 1'b0, start_time: 32'd0};
        end
      end
      S_RD: begin
        rd_a_q <= mem[i_idx];
        rd_b_q <= mem[last_idx];
      end
      S_LOAD: begin
        handle_q <= rd_a_q.handle;
        close_q  <= rd_a_q.is_close;
        p_q      <= 17'h10000;
        if (!rd_a_q.started) begin
          mem[i_idx] <= '{handle: rd_a_q.handle, is_close: rd_a_q.is_close,
                         started: 1'b1, start_time: cmd_q.time_ms};
        end
      end
      S_DIV: begin
        if (div_done) p_q <= {1'b0, div_quot};
      end
      S_MUL1: begin
        u_q   <= u_new;
        uu_q  <= u_new * u_new;
        idx_q <= (idx_wide > (ROM_W+1)'(CURVE_ROM_DEPTH - 1)) ?
                 ROM_W'(CURVE_ROM_DEPTH - 1) : idx_wide[ROM_W-1:0];
      end
      S_MUL2: begin
        rom_q  <= rom_tbl[idx_q];
        cube_q <= uu_q * {17'd0, u_q};
      end
      S_EASE: begin
        if (close_q) begin
          e_q <= ONE_Q14 - 16'((cube_q + (51'd1 << 33)) >> 34);
        end else if (p_q == 17'd0) begin
          e_q <= 16'd0;
        end else if (p_q[16]) begin
          e_q <= ONE_Q14;
        end else begin
          e_q <= rom_q;
        end
      end
      S_SCL: begin
        mul_q <= 29'(close_q ? CLOSE_SCALE_SPAN : OPEN_SCALE_SPAN) * 29'(e_q)
                 + 29'd8192;
      end
      S_OUT: begin
        if (out_free) begin
          res_q.out_handle <= handle_q;
          res_q.alpha      <= close_q ? 15'(ONE_Q14 - e_q) : e_q[14:0];
          res_q.scale      <= close_q ? 15'(ONE_Q14) - shifted
                                      : OPEN_SCALE_FROM + shifted;
          res_q.done_res   <= ent_done;
          res_q.last       <= (next_i >= next_count);
          if (ent_done) mem[i_idx] <= rd_b_q;
        end
      end
      S_FULL: begin
        if (out_free) begin
          res_q.out_handle <= cmd_q.handle;
          res_q.alpha      <= 15'd0;
          res_q.scale      <= CLOSE_SCALE_END;
          res_q.done_res   <= 1'b1;
          res_q.last       <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/efsa_checker.sv
// ----------------------------------------------------------------------------
// efsa_checker
// port-level checks of the animator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // a finished animation lands exactly on its end values
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[30:16] == 15'd0 && m_axis_tdata[45:31] == 15'd14418) ||
      (m_axis_tdata[30:16] == 15'd16384 && m_axis_tdata[45:31] == 15'd16384))
    else $error("done word with wrong end values");

  // scale never drops below the open start point
  a_scale_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[45:31] >= 15'd13926)
    else $error("scale below floor");

endmodule

bind eased_fade_scale_animator efsa_checker u_efsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

### test/eased_fade_scale_animator_test.sv
// ----------------------------------------------------------------------------
// eased_fade_scale_animator_test
// self-checking bench: open, close and tick words go in, alpha/scale words
// come out and are checked against a cycle-free model of the table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eased_fade_scale_animator_test;
  import efsa_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int ROM_DEPTH    = 1024;
  localparam int WATCHDOG_MAX = 20000;
  localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code, ignored
  localparam logic CFG_OPEN_DUR  = 1'b0;
  localparam logic CFG_CLOSE_DUR = 1'b1;
  localparam longint Q30 = 64'sd1 << 30;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] handle;
    logic [31:0] time_ms;
  } anim_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;    // handle[15:0], time_ms[47:16]
  logic [1:0]  s_axis_tuser;    // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;    // out_handle[15:0], alpha[30:16], scale[45:31]
  logic [0:0]  m_axis_tuser;    // done_res[0]
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;

  eased_fade_scale_animator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // model of the animation table
  // --------------------------------------------------------------------------
  logic [14:0] spring_rom [ROM_DEPTH];
  logic [15:0] open_dur;
  logic [15:0] close_dur;
  logic [15:0] tab_handle   [TABLE_DEPTH];
  logic        tab_is_close [TABLE_DEPTH];
  logic        tab_started  [TABLE_DEPTH];
  logic [31:0] tab_start    [TABLE_DEPTH];
  int          tab_count;

  result_t     pending_results[$];
  anim_word_t  word_q[$];

  // spring curve 1 - exp(-6x)cos(12x), via complex exp(c) raised to the 64th
  function automatic void build_spring_rom();
    longint den, cr, ci, tr, ti, sr, si, nr, ni, d;
    den = longint'(ROM_DEPTH - 1) * 64;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      cr = -((6 * Q30 * k + den / 2) / den);
      ci = (12 * Q30 * k + den / 2) / den;
      tr = Q30; ti = 0; sr = Q30; si = 0;
      for (int n = 1; n <= 7; n++) begin
        nr = (tr * cr - ti * ci) / Q30;
        ni = (tr * ci + ti * cr) / Q30;
        tr = nr / n;
        ti = ni / n;
        sr += tr;
        si += ti;
      end
      for (int n = 0; n < 6; n++) begin
        nr = (sr * sr - si * si) / Q30;
        ni = (2 * sr * si) / Q30;
        sr = nr;
        si = ni;
      end
      d = Q30 - sr;
      if (d < 0) d = 0;
      spring_rom[k] = 15'((d * 16384 + Q30 / 2) / Q30);
    end
  endfunction

  // ease value in q2.14 from progress in q0.16 (17 bits, 65536 = finished)
  function automatic logic [15:0] ease_q14(logic is_close, logic [16:0] p);
    logic [63:0] u, cube;
    logic [63:0] idx;
    if (is_close) begin
      u    = 64'(17'd65536 - p);
      cube = u * u * u;
      return 16'(64'd16384 - ((cube + (64'd1 << 33)) >> 34));
    end
    if (p == 0) return 16'd0;
    if (p[16]) return ONE_Q14;
    idx = (64'(p) * (ROM_DEPTH - 1) + 64'd32768) >> 16;
    return {1'b0, spring_rom[idx]};
  endfunction

  // apply one accepted word to the table and queue the words it yields
  function automatic void animate_word(anim_word_t w);
    int          i;
    int          first;
    logic [15:0] dur;
    logic [47:0] q;
    logic [16:0] p;
    logic [31:0] e;
    result_t     r;
    first = pending_results.size();
    case (w.action)
      ACT_OPEN, ACT_CLOSE: begin
        if (tab_count < TABLE_DEPTH) begin
          tab_handle[tab_count]   = w.handle;
          tab_is_close[tab_count] = (w.action == ACT_CLOSE);
          tab_started[tab_count]  = 1'b0;
          tab_start[tab_count]    = '0;
          tab_count++;
        end else if (w.action == ACT_CLOSE) begin
          // full table: the close is reported finished at once
          r.out_handle = w.handle;
          r.alpha      = '0;
          r.scale      = CLOSE_SCALE_END;
          r.done_res   = 1'b1;
          r.last       = 1'b1;
          pending_results.push_back(r);
        end
      end
      ACT_TICK: begin
        i = 0;
        while (i < tab_count) begin
          if (!tab_started[i]) begin
            tab_started[i] = 1'b1;
            tab_start[i]   = w.time_ms;
          end
          dur = tab_is_close[i] ? close_dur : open_dur;
          if (dur == 0) dur = 16'd1;
          q = {w.time_ms - tab_start[i], 16'd0} / 48'(dur);
          p = (q >= 48'd65536) ? 17'd65536 : 17'(q);
          e = 32'(ease_q14(tab_is_close[i], p));
          r.out_handle = tab_handle[i];
          if (tab_is_close[i]) begin
            r.alpha = 15'(32'd16384 - e);
            r.scale = 15'(32'd16384 - ((32'(CLOSE_SCALE_SPAN) * e + 32'd8192) >> 14));
          end else begin
            r.alpha = 15'(e);
            r.scale = 15'(32'(OPEN_SCALE_FROM)
                      + ((32'(OPEN_SCALE_SPAN) * e + 32'd8192) >> 14));
          end
          r.done_res = p[16];
          r.last     = 1'b0;
          pending_results.push_back(r);
          if (p[16]) begin
            // finished: last entry moves into this slot, same index again
            tab_count--;
            tab_handle[i]   = tab_handle[tab_count];
            tab_is_close[i] = tab_is_close[tab_count];
            tab_started[i]  = tab_started[tab_count];
            tab_start[i]    = tab_start[tab_count];
          end else begin
            i++;
          end
        end
        if (pending_results.size() > first)
          pending_results[pending_results.size() - 1].last = 1'b1;
      end
      default: ;  // unused action, no effect
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // input driver: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  anim_word_t offered;
  int         burst_left;
  int         gap_left;
  int         words_taken;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
      words_taken   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        animate_word(offered);
        words_taken <= words_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (word_q.size() > 0) begin
          offered       = word_q.pop_front();
          s_axis_tdata  <= {offered.time_ms, offered.handle};
          s_axis_tuser  <= offered.action;
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 12);
            // some bursts run back to back, others leave a gap behind
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: stall pattern of its own, plus long holds on request
  // --------------------------------------------------------------------------
  int hold_requests;
  int holds_served;
  int hold_left;
  int mode_left;
  int ready_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      holds_served  <= 0;
      hold_left     <= 0;
      mode_left     <= 0;
      ready_mode    <= 0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= 600;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left  <= $urandom_range(20, 300);
        ready_mode <= $urandom_range(0, 2);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  int      mismatches;
  result_t want;
  result_t got;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatches <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got.out_handle = m_axis_tdata[15:0];
      got.alpha      = m_axis_tdata[30:16];
      got.scale      = m_axis_tdata[45:31];
      got.done_res   = m_axis_tuser[0];
      got.last       = m_axis_tlast;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: handle %h alpha %0d scale %0d done %b last %b",
                   got.out_handle, got.alpha, got.scale, got.done_res, got.last);
        mismatches <= mismatches + 1;
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          if (mismatches < 10)
            $display({"result mismatch: expected handle %h alpha %0d scale %0d done %b ",
                      "last %b, got handle %h alpha %0d scale %0d done %b last %b"},
                     want.out_handle, want.alpha, want.scale, want.done_res, want.last,
                     got.out_handle, got.alpha, got.scale, got.done_res, got.last);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles without any handshake while work is outstanding
  // --------------------------------------------------------------------------
  int stuck_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                 || (cfg_valid_i && cfg_ready_o)
                 || (word_q.size() == 0 && !s_axis_tvalid && !cfg_valid_i
                     && pending_results.size() == 0)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  logic [31:0] now_ms;

  task automatic push_word(logic [1:0] action, logic [15:0] handle, logic [31:0] t);
    anim_word_t w;
    w.action  = action;
    w.handle  = handle;
    w.time_ms = t;
    word_q.push_back(w);
  endtask

  // sender waits until every queued word is taken and every result is in
  task automatic drain();
    do @(posedge clk_i);
    while (word_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_OPEN_DUR) open_dur = value;
    else close_dur = value;
  endtask

  // mostly opens, closes and ticks on an advancing clock; some time jumps
  task automatic random_words(int n, int step_max);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        push_word(ACT_OPEN, 16'($urandom), $urandom);
      end else if (r < 55) begin
        push_word(ACT_CLOSE, 16'($urandom), $urandom);
      end else if (r < 96) begin
        if ($urandom_range(0, 24) == 0) now_ms = $urandom;
        else now_ms += $urandom_range(0, step_max);
        push_word(ACT_TICK, 16'($urandom), now_ms);
      end else begin
        push_word(ACT_NONE, 16'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_data_i    = '0;
    hold_requests = 0;
    open_dur      = 16'd300;
    close_dur     = 16'd200;
    tab_count     = 0;
    build_spring_rom();
    @(posedge rst_ni);

    // reset durations: both curves, time wrapping past the top, unused action
    push_word(ACT_OPEN,  16'h0000, 32'hFFFF_FFFF);
    push_word(ACT_CLOSE, 16'hFFFF, 32'h0000_0000);
    push_word(ACT_TICK,  16'h5A5A, 32'hFFFF_FF00);
    push_word(ACT_TICK,  16'hA5A5, 32'h0000_0000);
    push_word(ACT_NONE,  16'hFFFF, 32'hFFFF_FFFF);
    push_word(ACT_TICK,  16'h0000, 32'h0000_0040);
    push_word(ACT_TICK,  16'h0000, 32'h0000_0100);
    push_word(ACT_TICK,  16'hFFFF, 32'h0000_0200);   // table empty
    drain();

    // longest durations: fill the table, then overflow with open and close
    write_reg(CFG_OPEN_DUR, 16'hFFFF);
    write_reg(CFG_CLOSE_DUR, 16'hFFFF);
    for (int k = 0; k < TABLE_DEPTH; k++)
      push_word((k % 3 == 0) ? ACT_CLOSE : ACT_OPEN, 16'($urandom), 32'd0);
    push_word(ACT_OPEN,  16'h1234, 32'd0);
    push_word(ACT_CLOSE, 16'hBEEF, 32'd0);
    push_word(ACT_TICK,  16'd0, 32'd1000);
    push_word(ACT_TICK,  16'd0, 32'd40000);
    hold_requests = hold_requests + 1;   // long result stall under a full tick
    push_word(ACT_TICK,  16'd0, 32'd70000);
    drain();

    // shortest durations, then zero which behaves as one
    write_reg(CFG_OPEN_DUR, 16'd1);
    write_reg(CFG_CLOSE_DUR, 16'd1);
    now_ms = $urandom;
    random_words(50, 2);
    drain();
    write_reg(CFG_OPEN_DUR, 16'd0);
    write_reg(CFG_CLOSE_DUR, 16'd0);
    random_words(30, 2);
    drain();

    // lopsided and random durations; results take several ticks to finish
    write_reg(CFG_OPEN_DUR, 16'hFFFF);
    write_reg(CFG_CLOSE_DUR, 16'd1);
    random_words(40, 8000);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_OPEN_DUR, 16'($urandom_range(1, 400)));
      write_reg(CFG_CLOSE_DUR, 16'($urandom_range(1, 400)));
      if (ph == 2) hold_requests = hold_requests + 1;
      random_words(32, 60);
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/efsa_pkg.sv
rtl/efsa_front.sv
rtl/efsa_div.sv
rtl/efsa_back.sv
rtl/eased_fade_scale_animator.sv
rtl/efsa_checker.sv
test/eased_fade_scale_animator_test.sv
